// ===== hdl/websocket_frame_deframer_macros.svh =====
// assertion macros used by the websocket deframer parser
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// condition holds in the same cycle as the trigger
`define WSD_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("wsd assertion failed");

// condition holds in the cycle after the trigger
`define WSD_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("wsd assertion failed");

`endif

// ===== hdl/wsd_pkg.sv =====
// types, constants and helpers for the websocket frame deframer
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  localparam logic [2:0] ST_DATA  = 3'd0;
  localparam logic [2:0] ST_CLOSE = 3'd1;
  localparam logic [2:0] ST_PING  = 3'd2;
  localparam logic [2:0] ST_PONG  = 3'd3;
  localparam logic [2:0] ST_TRUNC = 3'd4;

  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;
  localparam logic [3:0] OPC_PONG  = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } wsd_beat_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        frame_done;
    logic [2:0]  frame_status;
    logic [63:0] frame_length;
    logic [3:0]  frame_opcode;
    logic        final_flag;
  } wsd_result_t;

  function automatic logic [2:0] classify(input logic [3:0] opc);
    logic [2:0] st;
    case (opc)
      OPC_CLOSE: st = ST_CLOSE;
      OPC_PING:  st = ST_PING;
      OPC_PONG:  st = ST_PONG;
      default:   st = ST_DATA;
    endcase
    return st;
  endfunction

endpackage

// ===== hdl/wsd_if.sv =====
// valid/ready stream interfaces for received bytes and frame results
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, output data_byte, output chunk_end, input ready);
  modport sink (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic        frame_done;
  logic [2:0]  frame_status;
  logic [63:0] frame_length;
  logic [3:0]  frame_opcode;
  logic        final_flag;

  modport source (
    output valid, output payload_byte, output byte_valid, output frame_done,
    output frame_status, output frame_length, output frame_opcode,
    output final_flag, input ready
  );
  modport sink (
    input valid, input payload_byte, input byte_valid, input frame_done,
    input frame_status, input frame_length, input frame_opcode,
    input final_flag, output ready
  );
endinterface

// ===== hdl/wsd_parser.sv =====
// frame header state machine, payload unmasking and result formation
`include "websocket_frame_deframer_macros.svh"

module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  wsd_beat_t   beat,
  output logic        push,
  output wsd_result_t res
);

  phase_t      phase, phase_next;
  logic [3:0]  field_byte_count, field_byte_count_next;
  logic        fin_bit, fin_bit_next;
  logic [3:0]  opcode_reg, opcode_reg_next;
  logic        masked_bit, masked_bit_next;
  logic [63:0] declared_length, declared_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [63:0] remain, remain_next;
  logic [1:0]  key_idx, key_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR0;
      field_byte_count <= '0;
      fin_bit          <= 1'b0;
      opcode_reg       <= '0;
      masked_bit       <= 1'b0;
      declared_length  <= '0;
      mask_key         <= '0;
      remain           <= '0;
      key_idx          <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      fin_bit          <= fin_bit_next;
      opcode_reg       <= opcode_reg_next;
      masked_bit       <= masked_bit_next;
      declared_length  <= declared_length_next;
      mask_key         <= mask_key_next;
      remain           <= remain_next;
      key_idx          <= key_idx_next;
    end
  end

  always_comb begin
    logic       done;
    logic       have_byte;
    logic [7:0] pbyte;
    logic [7:0] key_byte;
    logic       len_ready;

    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    fin_bit_next          = fin_bit;
    opcode_reg_next       = opcode_reg;
    masked_bit_next       = masked_bit;
    declared_length_next  = declared_length;
    mask_key_next         = mask_key;
    remain_next           = remain;
    key_idx_next          = key_idx;
    done                  = 1'b0;
    have_byte             = 1'b0;
    pbyte                 = '0;
    key_byte              = '0;
    len_ready             = 1'b0;
    push                  = 1'b0;
    res                   = '0;

    case (phase)
      PH_HDR0: begin
        fin_bit_next          = beat.data_byte[7];
        opcode_reg_next       = beat.data_byte[3:0];
        masked_bit_next       = 1'b0;
        declared_length_next  = '0;
        mask_key_next         = '0;
        field_byte_count_next = '0;
        phase_next            = PH_HDR1;
      end
      PH_HDR1: begin
        masked_bit_next = beat.data_byte[7];
        if (beat.data_byte[6:0] == LEN_EXT16) begin
          phase_next            = PH_EXTLEN;
          field_byte_count_next = EXT16_BYTES;
        end else if (beat.data_byte[6:0] == LEN_EXT64) begin
          phase_next            = PH_EXTLEN;
          field_byte_count_next = EXT64_BYTES;
        end else begin
          declared_length_next = {57'd0, beat.data_byte[6:0]};
          len_ready            = 1'b1;
        end
      end
      PH_EXTLEN: begin
        declared_length_next  = {declared_length[55:0], beat.data_byte};
        field_byte_count_next = field_byte_count - 4'd1;
        len_ready             = (field_byte_count_next == '0);
      end
      PH_KEY: begin
        mask_key_next         = {mask_key[23:0], beat.data_byte};
        field_byte_count_next = field_byte_count - 4'd1;
        if (field_byte_count_next == '0) begin
          key_idx_next = '0;
          remain_next  = declared_length;
          if (declared_length == '0) begin
            done = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (masked_bit) begin
          case (key_idx)
            2'd0:    key_byte = mask_key[31:24];
            2'd1:    key_byte = mask_key[23:16];
            2'd2:    key_byte = mask_key[15:8];
            default: key_byte = mask_key[7:0];
          endcase
        end
        pbyte        = beat.data_byte ^ key_byte;
        have_byte    = 1'b1;
        key_idx_next = key_idx + 2'd1;
        remain_next  = remain - 64'd1;
        done         = (remain == 64'd1);
      end
      default: begin
        if (beat.chunk_end) begin
          phase_next = PH_HDR0;
        end
      end
    endcase

    // length known: fetch the key, go straight to payload, or finish an empty frame
    if (len_ready) begin
      if (masked_bit_next) begin
        phase_next            = PH_KEY;
        field_byte_count_next = KEY_BYTES;
      end else begin
        key_idx_next = '0;
        remain_next  = declared_length_next;
        if (declared_length_next == '0) begin
          done = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
    end

    if (phase != PH_DISCARD) begin
      if (done) begin
        phase_next = beat.chunk_end ? PH_HDR0 : PH_DISCARD;
        push       = 1'b1;
      end else if (beat.chunk_end) begin
        phase_next = PH_HDR0;
        push       = 1'b1;
      end else begin
        push = have_byte;
      end
    end

    res.payload_byte = pbyte;
    res.byte_valid   = have_byte;
    if (done || beat.chunk_end) begin
      res.frame_done   = 1'b1;
      res.frame_status = done ? classify(opcode_reg_next) : ST_TRUNC;
      res.frame_length = declared_length_next;
      res.frame_opcode = opcode_reg_next;
      res.final_flag   = fin_bit_next;
    end
  end

  `WSD_ASSERT_SAME(a_byte_only_in_payload, push && res.byte_valid, phase == PH_PAYLOAD)
  `WSD_ASSERT_NEXT(a_chunk_end_restarts, accept && beat.chunk_end, phase == PH_HDR0)
  `WSD_ASSERT_SAME(a_field_count_live, phase == PH_EXTLEN || phase == PH_KEY, field_byte_count != '0)
  `WSD_ASSERT_SAME(a_idle_fields_zero, push && !res.frame_done, res.frame_length == '0 && res.frame_status == ST_DATA)

endmodule

// ===== hdl/wsd_out_buf.sv =====
// two-entry result buffer that decouples the parser from the result sink
module wsd_out_buf import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  wsd_result_t res,
  output logic        space,
  wsd_out_if.source   result
);

  wsd_result_t entry [2];
  logic [1:0]  count;
  logic        wr_ptr;
  logic        rd_ptr;
  logic        pop;
  wsd_result_t head;

  assign space = (count != 2'd2);
  assign pop   = result.valid && result.ready;
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= res;
    end
  end

  assign result.valid        = (count != 2'd0);
  assign result.payload_byte = head.payload_byte;
  assign result.byte_valid   = head.byte_valid;
  assign result.frame_done   = head.frame_done;
  assign result.frame_status = head.frame_status;
  assign result.frame_length = head.frame_length;
  assign result.frame_opcode = head.frame_opcode;
  assign result.final_flag   = head.final_flag;

endmodule

// ===== hdl/websocket_frame_deframer.sv =====
// top level of the websocket frame deframer
//
//   channel  role    beat contents
//   stream   sink    data_byte, chunk_end
//   result   source  payload_byte, byte_valid, frame_done, frame_status,
//                    frame_length, frame_opcode, final_flag
//
// one byte per clock unless the buffer is full; each result is registered there
// the header and payload work of a byte sits between the parser state and the buffer
// rst is synchronous: parser waits for a header, buffer empties
// a two-entry result buffer absorbs sink stalls; stream.ready drops only when both
// entries hold results that have not been taken
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  wsd_in_if.sink    stream,
  wsd_out_if.source result
);

  logic        accept;
  logic        space;
  logic        push_raw;
  logic        push;
  wsd_beat_t   beat;
  wsd_result_t res;

  assign stream.ready   = space;
  assign accept         = stream.valid && space;
  assign beat.data_byte = stream.data_byte;
  assign beat.chunk_end = stream.chunk_end;
  assign push           = accept && push_raw;

  wsd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (beat),
    .push   (push_raw),
    .res    (res)
  );

  wsd_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .res    (res),
    .space  (space),
    .result (result)
  );

endmodule

// ===== tb/websocket_frame_deframer_tb.sv =====
// self-checking testbench for the websocket frame deframer
`timescale 1ns / 100ps

module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  localparam int IDLE_PERCENT   = 20;
  localparam int MAX_REPORTS    = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 10;

  localparam int LEN_FORM_SHORT = 0;
  localparam int LEN_FORM_16    = 1;
  localparam int LEN_FORM_64    = 2;

  logic clk = 1'b0;
  logic rst;

  wsd_in_if  stream_if ();
  wsd_out_if result_if ();

  websocket_frame_deframer DUT (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted parser state
  phase_t      rx_phase;
  logic [3:0]  rx_count;
  logic        rx_fin;
  logic [3:0]  rx_opcode;
  logic        rx_masked;
  logic [63:0] rx_length;
  logic [31:0] rx_key;
  logic [63:0] rx_payload_cnt;

  wsd_result_t expected_results[$];
  logic [7:0]  chunk_bytes[$];
  bit          idle_enable;
  int          bytes_sent;
  int          error_count = 0;
  int          quiet_cycles = 0;

  function automatic bit begin_payload();
    rx_payload_cnt = '0;
    if (rx_length == 64'd0) return 1'b1;
    rx_phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic bit length_complete();
    if (rx_masked) begin
      rx_phase = PH_KEY;
      rx_count = KEY_BYTES;
      return 1'b0;
    end
    return begin_payload();
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic last);
    wsd_result_t r;
    logic        done;
    logic        have_byte;
    logic [7:0]  key_byte;
    done      = 1'b0;
    have_byte = 1'b0;
    r         = '0;
    case (rx_phase)
      PH_HDR0: begin
        rx_fin         = b[7];
        rx_opcode      = b[3:0];
        rx_masked      = 1'b0;
        rx_length      = '0;
        rx_key         = '0;
        rx_payload_cnt = '0;
        rx_count       = '0;
        rx_phase       = PH_HDR1;
      end
      PH_HDR1: begin
        rx_masked = b[7];
        if (b[6:0] == LEN_EXT16) begin
          rx_phase = PH_EXTLEN;
          rx_count = EXT16_BYTES;
        end else if (b[6:0] == LEN_EXT64) begin
          rx_phase = PH_EXTLEN;
          rx_count = EXT64_BYTES;
        end else begin
          rx_length = {57'd0, b[6:0]};
          done      = length_complete();
        end
      end
      PH_EXTLEN: begin
        rx_length = {rx_length[55:0], b};
        rx_count  = rx_count - 4'd1;
        if (rx_count == 4'd0) done = length_complete();
      end
      PH_KEY: begin
        rx_key   = {rx_key[23:0], b};
        rx_count = rx_count - 4'd1;
        if (rx_count == 4'd0) done = begin_payload();
      end
      PH_PAYLOAD: begin
        key_byte       = rx_masked ? rx_key[8 * (3 - rx_payload_cnt[1:0]) +: 8] : 8'h00;
        r.payload_byte = b ^ key_byte;
        have_byte      = 1'b1;
        rx_payload_cnt = rx_payload_cnt + 64'd1;
        if (rx_payload_cnt == rx_length) done = 1'b1;
      end
      default: begin
        if (last) rx_phase = PH_HDR0;
        return;
      end
    endcase

    if (done) rx_phase = last ? PH_HDR0 : PH_DISCARD;
    else if (last) rx_phase = PH_HDR0;
    else if (!have_byte) return;

    r.byte_valid = have_byte;
    if (done || last) begin
      r.frame_done = 1'b1;
      if (!done) r.frame_status = ST_TRUNC;
      else begin
        case (rx_opcode)
          OPC_CLOSE: r.frame_status = ST_CLOSE;
          OPC_PING:  r.frame_status = ST_PING;
          OPC_PONG:  r.frame_status = ST_PONG;
          default:   r.frame_status = ST_DATA;
        endcase
      end
      r.frame_length = rx_length;
      r.frame_opcode = rx_opcode;
      r.final_flag   = rx_fin;
    end
    expected_results.push_back(r);
  endfunction

  function automatic string describe_result(input wsd_result_t r);
    return $sformatf("byte %02h/%0b done %0b status %0d len %016h opc %h fin %0b",
                     r.payload_byte, r.byte_valid, r.frame_done, r.frame_status,
                     r.frame_length, r.frame_opcode, r.final_flag);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
      stream_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    stream_if.valid     <= 1'b1;
    stream_if.data_byte <= b;
    stream_if.chunk_end <= last;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    deframe_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_chunk(input int n);
    for (int i = 0; i < n; i++) send_byte(chunk_bytes[i], i == n - 1);
    chunk_bytes.delete();
  endtask

  task automatic append_frame(input logic fin, input logic [3:0] opc, input logic masked,
                              input int len_form, input logic [63:0] plen,
                              input int payload_bytes);
    logic [2:0] rsv;
    logic [7:0] val;
    rsv = 3'($urandom_range(7));
    chunk_bytes.push_back({fin, rsv, opc});
    case (len_form)
      LEN_FORM_SHORT: chunk_bytes.push_back({masked, plen[6:0]});
      LEN_FORM_16: begin
        chunk_bytes.push_back({masked, LEN_EXT16});
        chunk_bytes.push_back(plen[15:8]);
        chunk_bytes.push_back(plen[7:0]);
      end
      default: begin
        chunk_bytes.push_back({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) chunk_bytes.push_back(plen[8 * i +: 8]);
      end
    endcase
    if (masked) begin
      repeat (KEY_BYTES) begin
        val = 8'($urandom_range(255));
        chunk_bytes.push_back(val);
      end
    end
    repeat (payload_bytes) begin
      val = 8'($urandom_range(255));
      chunk_bytes.push_back(val);
    end
  endtask

  task automatic random_chunk();
    int          pick;
    int          form;
    int          pay;
    int          cut;
    logic [63:0] plen;
    logic [15:0] len16;
    logic [3:0]  opc;
    logic [7:0]  val;
    logic        masked;
    logic        fin;
    if ($urandom_range(99) < 10) begin
      // noise chunk
      repeat ($urandom_range(1, 8)) begin
        val = 8'($urandom_range(255));
        chunk_bytes.push_back(val);
      end
      send_chunk(chunk_bytes.size());
    end else begin
      case ($urandom_range(6))
        0:       opc = 4'h0;
        1:       opc = 4'h1;
        2:       opc = 4'h2;
        3:       opc = OPC_CLOSE;
        4:       opc = OPC_PING;
        5:       opc = OPC_PONG;
        default: opc = 4'($urandom_range(15));
      endcase
      fin    = 1'($urandom_range(1));
      masked = 1'($urandom_range(1));
      pick   = int'($urandom_range(99));
      if (pick < 70) begin
        form = LEN_FORM_SHORT;
        plen = 64'($urandom_range(0, 20));
        if ($urandom_range(9) == 0) plen = 64'($urandom_range(21, 125));
      end else if (pick < 90) begin
        form  = LEN_FORM_16;
        len16 = 16'($urandom_range(16'hFFFF));
        plen  = ($urandom_range(3) == 0) ? {48'd0, len16} : 64'($urandom_range(0, 20));
      end else begin
        form = LEN_FORM_64;
        plen = ($urandom_range(3) == 0) ? {$urandom, $urandom} :
                                          64'($urandom_range(0, 20));
      end
      pay = (plen > 64'd125) ? int'($urandom_range(0, 6)) : int'(plen);
      append_frame(fin, opc, masked, form, plen, pay);
      if (plen == 64'(pay) && $urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          val = 8'($urandom_range(255));
          chunk_bytes.push_back(val);
        end
      end
      cut = chunk_bytes.size();
      if ($urandom_range(99) < 15) cut = int'($urandom_range(1, chunk_bytes.size()));
      send_chunk(cut);
    end
  endtask

  task automatic test_one_byte_chunk();
    chunk_bytes.push_back(8'hFF);
    send_chunk(1);
    chunk_bytes.push_back(8'h00);
    send_chunk(1);
  endtask

  task automatic test_control_frames();
    append_frame(1'b1, OPC_CLOSE, 1'b0, LEN_FORM_SHORT, 64'd0, 0);
    send_chunk(chunk_bytes.size());
    append_frame(1'b1, OPC_PING, 1'b1, LEN_FORM_SHORT, 64'd1, 1);
    send_chunk(chunk_bytes.size());
    // empty pong followed by bytes to drop
    append_frame(1'b0, OPC_PONG, 1'b0, LEN_FORM_SHORT, 64'd0, 0);
    chunk_bytes.push_back(8'hA5);
    chunk_bytes.push_back(8'h5A);
    send_chunk(chunk_bytes.size());
  endtask

  task automatic test_huge_length();
    append_frame(1'b0, 4'h2, 1'b0, LEN_FORM_64, '1, 1);
    send_chunk(chunk_bytes.size());
  endtask

  task automatic test_random_frames(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) random_chunk();
  endtask

  task automatic test_steady_stream(input int n_bytes);
    int target;
    target      = bytes_sent + n_bytes;
    idle_enable = 1'b0;
    while (bytes_sent < target) random_chunk();
    idle_enable = 1'b1;
  endtask

  always @(posedge clk) begin
    result_if.ready <= !idle_enable || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin : check_beats
    wsd_result_t seen;
    wsd_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      seen = {result_if.payload_byte, result_if.byte_valid, result_if.frame_done,
              result_if.frame_status, result_if.frame_length, result_if.frame_opcode,
              result_if.final_flag};
      if (expected_results.size() == 0) begin
        if (error_count < MAX_REPORTS) $display("unexpected beat: %s", describe_result(seen));
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (seen !== want) begin
          if (error_count < MAX_REPORTS) begin
            $display("mismatch expected: %s", describe_result(want));
            $display("         actual:   %s", describe_result(seen));
          end
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("websocket_frame_deframer_tb: errors");
      $finish;
    end
  end

  initial begin
    rst                 <= 1'b1;
    stream_if.valid     <= 1'b0;
    stream_if.data_byte <= 8'h00;
    stream_if.chunk_end <= 1'b0;
    idle_enable    = 1'b1;
    bytes_sent     = 0;
    rx_phase       = PH_HDR0;
    rx_count       = '0;
    rx_fin         = 1'b0;
    rx_opcode      = '0;
    rx_masked      = 1'b0;
    rx_length      = '0;
    rx_key         = '0;
    rx_payload_cnt = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_one_byte_chunk();
    test_control_frames();
    test_huge_length();
    test_random_frames(450);
    test_steady_stream(250);

    stream_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("websocket_frame_deframer_tb: clean");
    else
      $display("websocket_frame_deframer_tb: errors");
    $finish;
  end

endmodule
